// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int SCREEN_CELLS = COLUMNS * ROWS;
    localparam int LAST_ROW     = (ROWS - 1) * COLUMNS;   // first cell of the bottom row

    // Field widths
    localparam int CELL_W = 11;                // cell index, 0..SCREEN_CELLS
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 2 * BYTE_W;        // {attribute, character}

    // Stream widths
    localparam int S_DATA_W = 24;              // char_code + position, byte padded
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 32;              // result fields, byte padded

    localparam logic [BYTE_W-1:0] ATTR_NORMAL  = 8'h07;
    localparam logic [BYTE_W-1:0] CHAR_BLANK   = 8'h20;
    localparam logic [BYTE_W-1:0] ASCII_LF     = 8'd10;

    typedef logic [CELL_W-1:0] cell_idx_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [WORD_W-1:0] cell_word_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

endpackage

// ----- rtl/text_console_writer.sv -----
// Channel   Dir  Fields (lowest bit first)                      Transfer
// s_*       in   tuser: op[1:0]; tdata: char_code[7:0],         s_tvalid && s_tready
//                position[18:8], zero pad [23:19]
// m_*       out  tdata: cursor_cell[10:0], read_char[18:11],    m_tvalid && m_tready
//                read_attr[26:19], scrolled[27], zero pad
//
// Steps (accept to next accept): a plain put goes through accept, memory write
// and result load; an in-range newline through accept, cursor move and result
// load. An in-range read goes through accept with the RAM read, data capture
// and result load; an out-of-range read goes from accept to the result load.
// Set cursor runs a subtract-per-cycle column recovery. Clear walks the screen
// RAM, one cell per cycle. Each scroll is a pipelined copy through the single
// read and single write port, then a bottom-row fill; a newline at the end of
// a full screen scrolls twice.
// Reset: cursor and control clear asynchronously; the screen RAM is not
// cleared and holds garbage until a clear, put or scroll writes it.
// Stalls: a new item is taken while the previous result still waits on m_*;
// only the final result load waits for the output register to free up.
module text_console_writer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // char_code[7:0], position[18:8], zeros above
    input  logic [tcw_pkg::S_DATA_W-1:0]      s_tdata,
    // op[1:0]
    input  logic [tcw_pkg::S_USER_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cursor_cell[10:0], read_char[18:11], read_attr[26:19], scrolled[27], zeros above
    output logic [tcw_pkg::M_DATA_W-1:0]      m_tdata
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCROLL,   // copy rows up, read one row ahead of the write
        S_BLANK,    // fill bottom row after a scroll
        S_PUT,      // put or newline step; also where a put resumes after the pre-scroll
        S_CLEAR,
        S_MOD,      // column recovery for set cursor
        S_READ,
        S_EMIT
    } state_t;

    localparam int PAD_W = M_DATA_W - CELL_W - 2 * BYTE_W - 1;

    // Screen RAM: one write port, one registered read port
    cell_word_t mem [SCREEN_CELLS];
    cell_word_t rd_data_reg;
    logic       rd_en;
    cell_idx_t  rd_addr;
    logic       wr_en;
    cell_idx_t  wr_addr;
    cell_word_t wr_data;

    state_t             state_reg,   state_next;
    cell_idx_t          cursor_reg,  cursor_next;
    col_t               col_reg,     col_next;
    cell_idx_t          idx_reg,     idx_next;
    logic [BYTE_W-1:0]  char_reg,    char_next;
    logic               ret_put_reg, ret_put_next;
    logic               scr_reg,     scr_next;
    logic [BYTE_W-1:0]  rchar_reg,   rchar_next;
    logic [BYTE_W-1:0]  rattr_reg,   rattr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    op_t               in_op;
    logic [BYTE_W-1:0] in_char;
    cell_idx_t         in_pos;
    logic              in_xfer;
    cell_idx_t         nl_cursor;

    assign in_op    = op_t'(s_tuser[OP_W-1:0]);
    assign in_char  = s_tdata[BYTE_W-1:0];
    assign in_pos   = s_tdata[BYTE_W +: CELL_W];
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign nl_cursor = cursor_reg + CELL_W'(COLUMNS) - CELL_W'(col_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        col_next      = col_reg;
        idx_next      = idx_reg;
        char_next     = char_reg;
        ret_put_next  = ret_put_reg;
        scr_next      = scr_reg;
        rchar_next    = rchar_reg;
        rattr_next    = rattr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = {ATTR_NORMAL, CHAR_BLANK};

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    scr_next   = 1'b0;
                    rchar_next = '0;
                    rattr_next = '0;
                    char_next  = in_char;
                    state_next = S_EMIT;
                    case (in_op)
                        OP_PUT:
                        begin
                            if (cursor_reg >= CELL_W'(SCREEN_CELLS))
                            begin
                                ret_put_next = 1'b1;
                                idx_next     = '0;
                                state_next   = S_SCROLL;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            idx_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_SET:
                        begin
                            if (in_pos < CELL_W'(SCREEN_CELLS))
                            begin
                                cursor_next = in_pos;
                                idx_next    = in_pos;
                                state_next  = S_MOD;
                            end
                        end
                        OP_READ:
                        begin
                            if (in_pos < CELL_W'(SCREEN_CELLS))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = in_pos;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_SCROLL:
            begin
                if (idx_reg < CELL_W'(LAST_ROW))
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg + CELL_W'(COLUMNS);
                end
                if (idx_reg != '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - CELL_W'(1);
                    wr_data = rd_data_reg;
                end
                if (idx_reg == CELL_W'(LAST_ROW))
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    idx_next = idx_reg + CELL_W'(1);
                end
            end

            S_BLANK:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (idx_reg == CELL_W'(SCREEN_CELLS - 1))
                begin
                    cursor_next  = CELL_W'(LAST_ROW);
                    col_next     = '0;
                    scr_next     = 1'b1;
                    ret_put_next = 1'b0;
                    state_next   = ret_put_reg ? S_PUT : S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + CELL_W'(1);
                end
            end

            S_PUT:
            begin
                if (char_reg == ASCII_LF)
                begin
                    cursor_next = nl_cursor;
                    col_next    = '0;
                    if (nl_cursor >= CELL_W'(SCREEN_CELLS))
                    begin
                        idx_next   = '0;
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = cursor_reg;
                    wr_data     = {ATTR_NORMAL, char_reg};
                    cursor_next = cursor_reg + CELL_W'(1);
                    col_next    = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
                    state_next  = S_EMIT;
                end
            end

            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (idx_reg == CELL_W'(SCREEN_CELLS - 1))
                begin
                    cursor_next = '0;
                    col_next    = '0;
                    state_next  = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + CELL_W'(1);
                end
            end

            S_MOD:
            begin
                if (idx_reg >= CELL_W'(COLUMNS))
                begin
                    idx_next = idx_reg - CELL_W'(COLUMNS);
                end
                else
                begin
                    col_next   = idx_reg[COL_W-1:0];
                    state_next = S_EMIT;
                end
            end

            S_READ:
            begin
                rchar_next = rd_data_reg[BYTE_W-1:0];
                rattr_next = rd_data_reg[WORD_W-1:BYTE_W];
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {PAD_W'(0), scr_reg, rattr_reg, rchar_reg, cursor_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cursor_reg   <= '0;
            col_reg      <= '0;
            ret_put_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            col_reg      <= col_next;
            ret_put_reg  <= ret_put_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        char_reg    <= char_next;
        scr_reg     <= scr_next;
        rchar_reg   <= rchar_next;
        rattr_reg   <= rattr_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CELL_W'(SCREEN_CELLS))
        else $error("cursor beyond screen end");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(COLUMNS))
        else $error("column out of range");

    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_addr < CELL_W'(SCREEN_CELLS))
        else $error("screen write out of range");

    a_rd_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> rd_addr > wr_addr)
        else $error("scroll read fell behind write");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BLANK && idx_reg == CELL_W'(SCREEN_CELLS - 1))
        |=> (cursor_reg == CELL_W'(LAST_ROW) && scr_reg))
        else $error("scroll did not park cursor on bottom row");
`endif

endmodule

// ----- tb/text_console_writer_tb.sv -----
`timescale 1ns / 1ps

module text_console_writer_tb;

    import tcw_pkg::*;

    // Generous ceiling: far beyond the slowest legal run, where every item
    // would be a double scroll with the longest stalls on both sides.
    localparam int unsigned CYCLE_LIMIT   = 30_000_000;
    localparam int          ITEMS_PER_PHASE = 400;
    localparam int          DRAIN_CYCLES  = 40;   // idle time after the last result, to catch stray ones

    // One result as the block reports it, field by field.
    typedef struct packed {
        cell_idx_t   cursor_cell;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic        scrolled;
    } console_result_t;

    // Screen shadow, cursor shadow and the queue of results still owed by the block.
    class console_scoreboard;
        cell_word_t      screen [SCREEN_CELLS];
        bit              known  [SCREEN_CELLS];   // cell holds a defined value
        int unsigned     cursor;
        console_result_t owed_q [$];
        int              errors;
        int              checked;
        int              scroll_results;
        int              puts, newlines, reads, sets, clears;

        function new();
            cursor = 0;
        endfunction

        function void scroll_up();
            for (int i = 0; i < LAST_ROW; i++)
            begin
                screen[i] = screen[i + COLUMNS];
                known[i]  = known[i + COLUMNS];
            end
            for (int i = LAST_ROW; i < SCREEN_CELLS; i++)
            begin
                screen[i] = {ATTR_NORMAL, CHAR_BLANK};
                known[i]  = 1'b1;
            end
            cursor = LAST_ROW;
        endfunction

        // Apply one accepted transfer to the shadow and queue its result.
        function void note_input(op_t op, logic [7:0] ch, cell_idx_t pos);
            console_result_t r;
            r = '0;
            case (op)
                OP_PUT:
                begin
                    puts++;
                    if (cursor >= SCREEN_CELLS)
                    begin
                        scroll_up();
                        r.scrolled = 1'b1;
                    end
                    if (ch == ASCII_LF)
                    begin
                        newlines++;
                        cursor = cursor + (COLUMNS - cursor % COLUMNS);
                        if (cursor >= SCREEN_CELLS)
                        begin
                            scroll_up();
                            r.scrolled = 1'b1;
                        end
                    end
                    else
                    begin
                        screen[cursor] = {ATTR_NORMAL, ch};
                        known[cursor]  = 1'b1;
                        cursor++;
                    end
                end
                OP_CLEAR:
                begin
                    clears++;
                    foreach (screen[i])
                    begin
                        screen[i] = {ATTR_NORMAL, CHAR_BLANK};
                        known[i]  = 1'b1;
                    end
                    cursor = 0;
                end
                OP_SET:
                begin
                    sets++;
                    if (pos < SCREEN_CELLS)
                        cursor = 32'(pos);
                end
                default:
                begin
                    reads++;
                    if (pos < SCREEN_CELLS)
                    begin
                        r.read_char = screen[pos][7:0];
                        r.read_attr = screen[pos][15:8];
                    end
                end
            endcase
            r.cursor_cell = cell_idx_t'(cursor);
            if (r.scrolled)
                scroll_results++;
            owed_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 100)
                $display("tb: mismatch %0d at result %0d: %s", errors, checked, what);
        endtask

        task check_result(logic [M_DATA_W-1:0] data);
            console_result_t exp_r;
            if (owed_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", data));
                return;
            end
            exp_r = owed_q.pop_front();
            if (data[10:0] !== exp_r.cursor_cell)
                report_mismatch($sformatf("cursor_cell %0d, want %0d",
                                          data[10:0], exp_r.cursor_cell));
            if (data[18:11] !== exp_r.read_char)
                report_mismatch($sformatf("read_char %h, want %h",
                                          data[18:11], exp_r.read_char));
            if (data[26:19] !== exp_r.read_attr)
                report_mismatch($sformatf("read_attr %h, want %h",
                                          data[26:19], exp_r.read_attr));
            if (data[27] !== exp_r.scrolled)
                report_mismatch($sformatf("scrolled %b, want %b",
                                          data[27], exp_r.scrolled));
            if (data[M_DATA_W-1:28] !== '0)
                report_mismatch($sformatf("pad bits %h not zero", data[M_DATA_W-1:28]));
            checked++;
        endtask
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic [S_USER_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    int unsigned cycles     = 0;
    int          send_idle  = 0;   // percent of cycles the source holds back
    int          recv_stall = 0;   // percent of cycles the sink refuses

    console_scoreboard sb = new();

    text_console_writer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // char_code[7:0], position[18:8], zeros above
        .s_tuser  (s_tuser),    // op[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // cursor_cell[10:0], read_char[18:11], read_attr[26:19],
                                // scrolled[27], zeros above
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sink side: random back-pressure, redrawn every cycle.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    // Result monitor; values sampled here are the ones the edge saw.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // Present one item, hold it until the block takes it, then update the shadow.
    // tvalid stays high straight into the next item when no gap is drawn.
    task automatic send_item(input op_t op, input logic [7:0] ch, input cell_idx_t pos);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - 19){1'b0}}, pos, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(op, ch, pos);
    endtask

    // Random item, biased so the cursor spends a lot of time on the bottom
    // rows: that is where scrolls and double scrolls happen.
    task automatic send_random();
        int unsigned pick;
        op_t         op;
        logic [7:0]  ch;
        cell_idx_t   pos;
        pick = $urandom_range(99);
        ch   = 8'($urandom_range(255));
        pos  = cell_idx_t'($urandom_range(2047));
        if (pick < 55)
        begin
            op = OP_PUT;
            if ($urandom_range(99) < 15)
                ch = ASCII_LF;
        end
        else if (pick < 72)
        begin
            op = OP_SET;
            case ($urandom_range(4))
                2, 3:    pos = cell_idx_t'($urandom_range(SCREEN_CELLS - 1,
                                                          SCREEN_CELLS - 2 * COLUMNS));
                4:       pos = cell_idx_t'($urandom_range(2047, SCREEN_CELLS - 8));
                default: ;
            endcase
        end
        else if (pick < 97)
        begin
            op = OP_READ;
            // half the reads look back at what was just written
            if ($urandom_range(1) == 0)
                pos = (sb.cursor > 3) ? cell_idx_t'(sb.cursor - 1 - $urandom_range(2)) : '0;
            // never touch a cell that holds no defined value yet
            if (pos < SCREEN_CELLS && !sb.known[pos])
                pos = cell_idx_t'(SCREEN_CELLS + $urandom_range(47));
        end
        else
            op = OP_CLEAR;
        send_item(op, ch, pos);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: before any clear only written cells are read back.
        send_item(OP_PUT,   8'h41, 11'd0);        // 'A' into cell 0
        send_item(OP_PUT,   8'h00, 11'd0);        // lowest byte into cell 1
        send_item(OP_PUT,   8'hff, 11'd0);        // highest byte into cell 2
        send_item(OP_READ,  8'h00, 11'd0);
        send_item(OP_READ,  8'h00, 11'd1);
        send_item(OP_READ,  8'h00, 11'd2);
        send_item(OP_READ,  8'h00, 11'd2047);     // out of range reads as zero
        send_item(OP_SET,   8'h00, 11'd2000);     // out of range, ignored
        send_item(OP_SET,   8'h00, 11'd2047);     // ignored as well
        send_item(OP_PUT,   ASCII_LF, 11'd0);     // newline mid-row
        send_item(OP_CLEAR, 8'h00, 11'd0);
        send_item(OP_READ,  8'h00, 11'd1999);     // blank after clear
        send_item(OP_SET,   8'h00, 11'd1999);
        send_item(OP_PUT,   8'h5a, 11'd0);        // cursor lands one past the end
        send_item(OP_READ,  8'h00, 11'd1999);
        send_item(OP_PUT,   ASCII_LF, 11'd0);     // scroll before and after the newline
        send_item(OP_READ,  8'h00, 11'd1839);     // 'Z' moved up two rows
        send_item(OP_SET,   8'h00, 11'd1999);
        send_item(OP_PUT,   8'h78, 11'd0);
        send_item(OP_PUT,   8'h79, 11'd0);        // put at the end scrolls first
        send_item(OP_SET,   8'h00, 11'd1950);
        send_item(OP_PUT,   ASCII_LF, 11'd0);     // newline off the bottom row
        send_item(OP_SET,   8'h00, 11'd1040);
        send_item(OP_READ,  8'h00, 11'd1040);
        send_item(OP_READ,  8'h00, 11'd1919);

        // Random phases with different idle patterns on each side.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 66; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 66; end
                default: begin send_idle = 6;  recv_stall = 6;  end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_random();
        end
        s_tvalid <= 1'b0;

        // Let the block finish, then linger to catch stray results.
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d results checked in %0d cycles; %0d of them reported a scroll",
                 sb.checked, cycles, sb.scroll_results);
        $display("tb: %0d puts (%0d newlines), %0d reads, %0d cursor sets, %0d clears",
                 sb.puts, sb.newlines, sb.reads, sb.sets, sb.clears);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tcw_pkg.sv
rtl/text_console_writer.sv
tb/text_console_writer_tb.sv
